/* design/mlft_pkg.sv */
// Shared types and constants for the MAC learning forwarding table.
// Used by mlft_regs, mlft_ctrl, mlft_dp and the top module; depends on nothing.
`default_nettype none
package mlft_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_PORT_COUNT  = 16;

  localparam int MAC_W   = 48;
  localparam int PORT_W  = 4;
  localparam int LIMIT_W = 5;
  localparam int APB_AW  = 2;
  localparam int APB_DW  = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [APB_AW-1:0] REG_TABLE_LIMIT = 2'd0;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_LEARN = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
  } ctrl_stat_t;

endpackage
`default_nettype wire

/* design/mlft_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none
module mlft_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/mlft_regs.sv */
// APB configuration register (table_limit) for the forwarding table.
// Depends on mlft_pkg.
`default_nettype none
module mlft_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mlft_pkg::APB_AW-1:0]   paddr,
  input  wire logic [mlft_pkg::APB_DW-1:0]   pwdata,
  output logic      [mlft_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output logic      [mlft_pkg::LIMIT_W-1:0]  table_limit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == mlft_pkg::REG_TABLE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_limit <= mlft_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      table_limit <= pwdata[mlft_pkg::LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == mlft_pkg::REG_TABLE_LIMIT) begin
      prdata = mlft_pkg::APB_DW'(table_limit);
    end
  end

endmodule
`default_nettype wire

/* design/mlft_ctrl.sv */
// Controller state machine: sequences load, table scan, drain and finish.
// Depends on mlft_pkg.
`default_nettype none
module mlft_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire mlft_pkg::ctrl_stat_t stat,
  output mlft_pkg::ctrl_cmd_t       cmd
);

  mlft_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlft_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mlft_pkg::ST_IDLE: begin
        if (start) begin
          state_next = mlft_pkg::ST_SCAN;
        end
      end
      mlft_pkg::ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = mlft_pkg::ST_DRAIN;
        end
      end
      mlft_pkg::ST_DRAIN:  state_next = mlft_pkg::ST_FINISH;
      mlft_pkg::ST_FINISH: state_next = mlft_pkg::ST_IDLE;
      default:             state_next = mlft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      mlft_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      mlft_pkg::ST_SCAN: begin
        cmd.issue = !stat.scan_done;
      end
      mlft_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      mlft_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/mlft_dp.sv */
// Datapath: request capture, entry scan compare, learn decision, result registers.
// Depends on mlft_pkg and mlft_ram.
`default_nettype none
module mlft_dp #(
  parameter int TABLE_DEPTH = mlft_pkg::DEF_TABLE_DEPTH,
  parameter int PORT_COUNT  = mlft_pkg::DEF_PORT_COUNT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mlft_pkg::ctrl_cmd_t           cmd,
  output mlft_pkg::ctrl_stat_t               stat,
  input  wire logic [mlft_pkg::LIMIT_W-1:0]  table_limit,
  input  wire logic                          op,
  input  wire logic [mlft_pkg::MAC_W-1:0]    src_mac,
  input  wire logic [mlft_pkg::MAC_W-1:0]    dst_mac,
  input  wire logic [mlft_pkg::PORT_W-1:0]   ingress_port,
  output logic                               done,
  output logic                               hit,
  output logic      [mlft_pkg::PORT_W-1:0]   out_port,
  output logic                               flood,
  output logic                               learned,
  output logic                               table_full
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int LW    = (CW > mlft_pkg::LIMIT_W) ? CW : mlft_pkg::LIMIT_W;
  localparam int PCW0  = $clog2(PORT_COUNT + 1);
  localparam int PCW   = (PCW0 > mlft_pkg::PORT_W) ? PCW0 : mlft_pkg::PORT_W;
  localparam int ENT_W = mlft_pkg::MAC_W + mlft_pkg::PORT_W;

  logic                         op_q;
  logic [mlft_pkg::MAC_W-1:0]   src_q;
  logic [mlft_pkg::MAC_W-1:0]   dst_q;
  logic [mlft_pkg::PORT_W-1:0]  port_q;
  logic [CW-1:0]                idx;
  logic [CW-1:0]                entry_count;
  logic                         cmp_valid;
  logic                         dst_hit;
  logic [mlft_pkg::PORT_W-1:0]  dst_port;
  logic                         src_hit;

  logic [ENT_W-1:0]             rd_data;
  logic [mlft_pkg::MAC_W-1:0]   rd_mac;
  logic [mlft_pkg::PORT_W-1:0]  rd_port;

  logic is_frame;
  logic need_learn;
  logic port_ok;
  logic room;
  logic do_write;
  logic do_full;

  assign rd_mac  = rd_data[mlft_pkg::MAC_W-1:0];
  assign rd_port = rd_data[ENT_W-1:mlft_pkg::MAC_W];

  assign stat.scan_done = (idx == entry_count);

  assign is_frame   = (op_q == mlft_pkg::OP_FRAME);
  assign need_learn = !is_frame || !dst_hit;
  assign port_ok    = PCW'(port_q) < PCW'(PORT_COUNT);
  assign room       = (LW'(entry_count) < LW'(table_limit)) &&
                      (entry_count < CW'(TABLE_DEPTH));
  assign do_write   = cmd.finish && need_learn && port_ok && !src_hit && room;
  assign do_full    = need_learn && port_ok && !src_hit && !room;

  mlft_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (entry_count[AW-1:0]),
    .wdata ({port_q, src_q}),
    .raddr (idx[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op;
      src_q  <= src_mac;
      dst_q  <= dst_mac;
      port_q <= ingress_port;
    end
  end

  // Scan: issue one read per cycle, compare the entry in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      idx       <= '0;
    end else begin
      cmp_valid <= cmd.issue;
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.issue) begin
        idx <= idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dst_hit  <= 1'b0;
      dst_port <= '0;
      src_hit  <= 1'b0;
    end else if (cmp_valid) begin
      if (!dst_hit && (rd_mac == dst_q)) begin
        dst_hit  <= 1'b1;
        dst_port <= rd_port;
      end
      if (rd_mac == src_q) begin
        src_hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (do_write) begin
        entry_count <= entry_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit        <= is_frame && dst_hit;
      out_port   <= (is_frame && dst_hit) ? dst_port : '0;
      flood      <= is_frame && !dst_hit;
      learned    <= do_write;
      table_full <= do_full;
    end
  end

endmodule
`default_nettype wire

/* design/mac_learning_forward_table_top.sv */
// MAC learning forwarding table: one request in, one result out per request.
// An item is captured, scanned against every stored entry, then passes the drain and finish
// states before the done cycle; the scan reads one entry per cycle through a single RAM read port.
// A new request can be accepted in the cycle that done is high. The receiver cannot stall.
// Synchronous reset empties the table (entry count 0) and sets table_limit to 16.
// Depends on mlft_pkg, mlft_regs, mlft_ctrl, mlft_dp and mlft_ram.
`default_nettype none
module mac_learning_forward_table_top #(
  parameter int TABLE_DEPTH = mlft_pkg::DEF_TABLE_DEPTH,
  parameter int PORT_COUNT  = mlft_pkg::DEF_PORT_COUNT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         op,
  input  wire logic [mlft_pkg::MAC_W-1:0]   src_mac,
  input  wire logic [mlft_pkg::MAC_W-1:0]   dst_mac,
  input  wire logic [mlft_pkg::PORT_W-1:0]  ingress_port,
  output logic                              done,
  output logic                              hit,
  output logic      [mlft_pkg::PORT_W-1:0]  out_port,
  output logic                              flood,
  output logic                              learned,
  output logic                              table_full,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mlft_pkg::APB_AW-1:0]  paddr,
  input  wire logic [mlft_pkg::APB_DW-1:0]  pwdata,
  output logic      [mlft_pkg::APB_DW-1:0]  prdata,
  output logic                              pready
);

  mlft_pkg::ctrl_cmd_t            cmd;
  mlft_pkg::ctrl_stat_t           stat;
  logic [mlft_pkg::LIMIT_W-1:0]   table_limit;

  mlft_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .table_limit (table_limit)
  );

  mlft_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mlft_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PORT_COUNT  (PORT_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .table_limit  (table_limit),
    .op           (op),
    .src_mac      (src_mac),
    .dst_mac      (dst_mac),
    .ingress_port (ingress_port),
    .done         (done),
    .hit          (hit),
    .out_port     (out_port),
    .flood        (flood),
    .learned      (learned),
    .table_full   (table_full)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a request is still in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_hit_flood: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && flood))
    else $error("hit and flood reported together");

  a_learn_full: assert property (@(posedge clk) disable iff (rst)
    done |-> !(learned && table_full))
    else $error("learned and table_full reported together");

endmodule
`default_nettype wire
